### rtl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// RPN calculator core package
// Shared widths, key codes, command and handshake types for the calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsc_pkg;

    localparam int DIGITS  = 10;
    localparam int KEY_W   = 6;
    localparam int VALUE_W = 35;
    localparam int ENTRY_W = 34;
    localparam int MAG_W   = 34;
    localparam int CNT_W   = $clog2(DIGITS + 1);
    localparam int STEP_W  = $clog2(MAG_W);

    localparam logic [ENTRY_W-1:0]        VAL_LIMIT = 34'd9999999999;
    localparam logic signed [VALUE_W-1:0] POS_LIMIT = 35'sd9999999999;
    localparam logic signed [VALUE_W-1:0] NEG_LIMIT = -POS_LIMIT;

    localparam logic [KEY_W-1:0] KEY_D7    = 6'd6;
    localparam logic [KEY_W-1:0] KEY_D8    = 6'd7;
    localparam logic [KEY_W-1:0] KEY_D9    = 6'd8;
    localparam logic [KEY_W-1:0] KEY_D4    = 6'd16;
    localparam logic [KEY_W-1:0] KEY_D5    = 6'd17;
    localparam logic [KEY_W-1:0] KEY_D6    = 6'd18;
    localparam logic [KEY_W-1:0] KEY_D1    = 6'd26;
    localparam logic [KEY_W-1:0] KEY_D2    = 6'd27;
    localparam logic [KEY_W-1:0] KEY_D3    = 6'd28;
    localparam logic [KEY_W-1:0] KEY_D0    = 6'd36;
    localparam logic [KEY_W-1:0] KEY_ENTER = 6'd25;
    localparam logic [KEY_W-1:0] KEY_CLX   = 6'd24;
    localparam logic [KEY_W-1:0] KEY_SWAP  = 6'd23;
    localparam logic [KEY_W-1:0] KEY_ROLL  = 6'd22;
    localparam logic [KEY_W-1:0] KEY_ON    = 6'd30;
    localparam logic [KEY_W-1:0] KEY_DIV   = 6'd9;
    localparam logic [KEY_W-1:0] KEY_MUL   = 6'd19;
    localparam logic [KEY_W-1:0] KEY_SUB   = 6'd29;
    localparam logic [KEY_W-1:0] KEY_ADD   = 6'd39;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_DIGIT,
        OP_ENTER,
        OP_CLX,
        OP_SWAP,
        OP_ROLL,
        OP_ON,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] digit;
    } t_cmd;

    typedef struct packed {
        logic   start;
        logic   is_div;
        t_value a;
        t_value b;
    } t_md_req;

    typedef struct packed {
        logic   done;
        t_value result;
    } t_md_rsp;

    typedef enum logic {
        ST_EXEC,
        ST_WAIT
    } t_back_state;

endpackage

### rtl/rpn_stack_calculator_core.sv
// ----------------------------------------------------------------------------
// RPN stack calculator core
// A key passes through the command queue and the registered result outputs;
// multiply and divide also wait on the one-bit-per-cycle multiply/divide unit.
// Throughput: one key per cycle for simple keys while the output is not stalled,
// none while a multiply or divide runs; a two-entry command queue sits between
// decode and execution. Reset clears the stack, entry, entry/blank flags and queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_stack_calculator_core import rsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // Fields from bit 0: key_code[5:0], zero fill.
    input  logic [7:0]  i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // Fields from bit 0: shown_value[34:0], screen_blank, entry_active,
    // divide_fault, zero fill.
    output logic [39:0] o_m_axis_tdata
);

    logic    cmd_valid;
    logic    cmd_ready;
    t_cmd    cmd;
    t_md_req md_req;
    t_md_rsp md_rsp;
    t_value  shown_value;
    logic    screen_blank;
    logic    entry_active;
    logic    divide_fault;

    rsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_valid (i_s_axis_tvalid),
        .o_key_ready (o_s_axis_tready),
        .i_key_code  (i_s_axis_tdata[KEY_W-1:0]),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    rsc_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    rsc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .o_cmd_ready    (cmd_ready),
        .i_cmd          (cmd),
        .o_md_req       (md_req),
        .i_md_rsp       (md_rsp),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_shown_value  (shown_value),
        .o_screen_blank (screen_blank),
        .o_entry_active (entry_active),
        .o_divide_fault (divide_fault)
    );

    assign o_m_axis_tdata = {2'b00, divide_fault, entry_active, screen_blank, shown_value};

endmodule

### rtl/rsc_front.sv
// ----------------------------------------------------------------------------
// RPN calculator key front end
// Accepts key codes, decodes them into commands and queues them for execution.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsc_front import rsc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_key_valid,
    output logic             o_key_ready,
    input  logic [KEY_W-1:0] i_key_code,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output t_cmd             o_cmd
);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    t_cmd              decoded;
    logic              push;
    logic              pop;

    always_comb begin
        decoded.op    = OP_NOP;
        decoded.digit = 4'd0;
        unique case (i_key_code)
            KEY_D0: begin decoded.op = OP_DIGIT; decoded.digit = 4'd0; end
            KEY_D1: begin decoded.op = OP_DIGIT; decoded.digit = 4'd1; end
            KEY_D2: begin decoded.op = OP_DIGIT; decoded.digit = 4'd2; end
            KEY_D3: begin decoded.op = OP_DIGIT; decoded.digit = 4'd3; end
            KEY_D4: begin decoded.op = OP_DIGIT; decoded.digit = 4'd4; end
            KEY_D5: begin decoded.op = OP_DIGIT; decoded.digit = 4'd5; end
            KEY_D6: begin decoded.op = OP_DIGIT; decoded.digit = 4'd6; end
            KEY_D7: begin decoded.op = OP_DIGIT; decoded.digit = 4'd7; end
            KEY_D8: begin decoded.op = OP_DIGIT; decoded.digit = 4'd8; end
            KEY_D9: begin decoded.op = OP_DIGIT; decoded.digit = 4'd9; end
            KEY_ENTER: decoded.op = OP_ENTER;
            KEY_CLX:   decoded.op = OP_CLX;
            KEY_SWAP:  decoded.op = OP_SWAP;
            KEY_ROLL:  decoded.op = OP_ROLL;
            KEY_ON:    decoded.op = OP_ON;
            KEY_DIV:   decoded.op = OP_DIV;
            KEY_MUL:   decoded.op = OP_MUL;
            KEY_SUB:   decoded.op = OP_SUB;
            KEY_ADD:   decoded.op = OP_ADD;
            default:   decoded.op = OP_NOP;
        endcase
    end

    assign o_key_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign push        = i_key_valid & o_key_ready;
    assign pop         = o_cmd_valid & i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= decoded;
        end
    end

endmodule

### rtl/rsc_muldiv.sv
// ----------------------------------------------------------------------------
// RPN calculator multiply and divide unit
// Bit-serial saturating multiply and restoring divide on value magnitudes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsc_muldiv import rsc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_md_req i_req,
    output t_md_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic              r_is_div;
    logic              r_neg;
    logic [MAG_W-1:0]  r_mc;
    logic [MAG_W-1:0]  r_md;
    logic [MAG_W+1:0]  r_acc;

    logic [MAG_W+1:0]  mul_sum;
    logic [MAG_W+1:0]  div_shift;
    logic              div_ge;
    logic [MAG_W+1:0]  n_acc;
    logic [MAG_W-1:0]  n_mc;
    logic [MAG_W-1:0]  mag_res;
    t_value            ext_res;

    function automatic logic [MAG_W-1:0] magnitude(input t_value v);
        logic [VALUE_W-1:0] u;
        begin
            u = v[VALUE_W-1] ? VALUE_W'(-v) : VALUE_W'(v);
            return u[MAG_W-1:0];
        end
    endfunction

    always_comb begin
        mul_sum   = {r_acc[MAG_W:0], 1'b0} + (r_mc[MAG_W-1] ? {2'b00, r_md} : '0);
        div_shift = {r_acc[MAG_W:0], r_mc[MAG_W-1]};
        div_ge    = (div_shift >= {2'b00, r_md});
        if (r_is_div) begin
            n_acc = div_ge ? (div_shift - {2'b00, r_md}) : div_shift;
            n_mc  = {r_mc[MAG_W-2:0], div_ge};
        end else begin
            n_acc = (mul_sum > {2'b00, VAL_LIMIT}) ? {2'b00, VAL_LIMIT} : mul_sum;
            n_mc  = {r_mc[MAG_W-2:0], 1'b0};
        end
        mag_res      = r_is_div ? r_mc : r_acc[MAG_W-1:0];
        ext_res      = $signed({1'b0, mag_res});
        o_rsp.done   = r_done;
        o_rsp.result = r_neg ? -ext_res : ext_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_is_div <= i_req.is_div;
            r_neg    <= i_req.a[VALUE_W-1] ^ i_req.b[VALUE_W-1];
            r_mc     <= i_req.is_div ? magnitude(i_req.b) : magnitude(i_req.a);
            r_md     <= i_req.is_div ? magnitude(i_req.a) : magnitude(i_req.b);
            r_acc    <= '0;
        end else if (r_busy) begin
            r_mc  <= n_mc;
            r_acc <= n_acc;
        end
    end

endmodule

### rtl/rsc_back.sv
// ----------------------------------------------------------------------------
// RPN calculator execution back end
// Holds the stack and entry state, executes commands and registers results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsc_back import rsc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    output logic    o_cmd_ready,
    input  t_cmd    i_cmd,
    output t_md_req o_md_req,
    input  t_md_rsp i_md_rsp,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_value  o_shown_value,
    output logic    o_screen_blank,
    output logic    o_entry_active,
    output logic    o_divide_fault
);

    t_back_state        r_state, n_state;
    t_value             r_stack [4];
    t_value             n_stack [4];
    t_value             c_stack [4];
    logic [ENTRY_W-1:0] r_entry, n_entry;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_entry_flag, n_entry_flag;
    logic               r_blank, n_blank;
    logic               r_out_valid, n_out_valid;
    t_value             r_shown, n_shown;
    logic               r_blank_out, n_blank_out;
    logic               r_active_out, n_active_out;
    logic               r_fault_out, n_fault_out;

    logic               take;
    logic               load_out;
    logic               fault;
    logic [ENTRY_W-1:0] base_entry;
    logic [CNT_W-1:0]   base_count;
    logic [ENTRY_W+3:0] digit_val;
    logic [VALUE_W:0]   arith_sum;

    function automatic t_value clamp_sum(input logic signed [VALUE_W:0] v);
        logic signed [VALUE_W:0] hi;
        logic signed [VALUE_W:0] lo;
        begin
            hi = (VALUE_W + 1)'(POS_LIMIT);
            lo = (VALUE_W + 1)'(NEG_LIMIT);
            if (v > hi) begin
                return POS_LIMIT;
            end else if (v < lo) begin
                return NEG_LIMIT;
            end
            return v[VALUE_W-1:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EXEC;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_stack[i] <= '0;
            end
            r_entry      <= '0;
            r_count      <= '0;
            r_entry_flag <= 1'b0;
            r_blank      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            for (int i = 0; i < 4; i++) begin
                r_stack[i] <= n_stack[i];
            end
            r_entry      <= n_entry;
            r_count      <= n_count;
            r_entry_flag <= n_entry_flag;
            r_blank      <= n_blank;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shown      <= n_shown;
        r_blank_out  <= n_blank_out;
        r_active_out <= n_active_out;
        r_fault_out  <= n_fault_out;
    end

    always_comb begin
        n_state      = r_state;
        n_stack      = r_stack;
        n_entry      = r_entry;
        n_count      = r_count;
        n_entry_flag = r_entry_flag;
        n_blank      = r_blank;
        load_out     = 1'b0;
        fault        = 1'b0;

        o_cmd_ready     = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);
        take            = i_cmd_valid && o_cmd_ready;
        o_md_req.start  = 1'b0;
        o_md_req.is_div = (i_cmd.op == OP_DIV);

        if (r_entry_flag) begin
            c_stack[0] = $signed({1'b0, r_entry});
            c_stack[1] = r_stack[0];
            c_stack[2] = r_stack[1];
            c_stack[3] = r_stack[2];
        end else begin
            c_stack = r_stack;
        end
        o_md_req.a = c_stack[0];
        o_md_req.b = c_stack[1];

        base_entry = r_entry_flag ? r_entry : '0;
        base_count = r_entry_flag ? r_count : '0;
        digit_val  = ({4'b0000, base_entry} << 3) + ({4'b0000, base_entry} << 1)
                   + {{ENTRY_W{1'b0}}, i_cmd.digit};
        if (i_cmd.op == OP_SUB) begin
            arith_sum = {c_stack[1][VALUE_W-1], c_stack[1]}
                      - {c_stack[0][VALUE_W-1], c_stack[0]};
        end else begin
            arith_sum = {c_stack[1][VALUE_W-1], c_stack[1]}
                      + {c_stack[0][VALUE_W-1], c_stack[0]};
        end

        unique case (r_state)
            ST_EXEC: begin
                if (take) begin
                    load_out = 1'b1;
                    unique case (i_cmd.op)
                        OP_DIGIT: begin
                            n_entry_flag = 1'b1;
                            if (base_count < CNT_W'(DIGITS)) begin
                                n_entry = (digit_val > {4'b0000, VAL_LIMIT}) ? VAL_LIMIT
                                        : digit_val[ENTRY_W-1:0];
                                n_count = base_count + 1'b1;
                            end else begin
                                n_entry = base_entry;
                                n_count = base_count;
                            end
                        end
                        OP_ENTER: begin
                            n_stack[0]   = c_stack[0];
                            n_stack[1]   = r_stack[0];
                            n_stack[2]   = r_stack[1];
                            n_stack[3]   = r_stack[2];
                            n_entry_flag = 1'b0;
                        end
                        OP_CLX: begin
                            if (r_entry_flag) begin
                                n_entry_flag = 1'b0;
                            end else begin
                                n_stack[0] = '0;
                            end
                        end
                        OP_SWAP: begin
                            n_stack      = c_stack;
                            n_stack[0]   = c_stack[1];
                            n_stack[1]   = c_stack[0];
                            n_entry_flag = 1'b0;
                        end
                        OP_ROLL: begin
                            n_stack[0] = r_stack[1];
                            n_stack[1] = r_stack[2];
                            n_stack[2] = r_stack[3];
                            n_stack[3] = r_stack[0];
                        end
                        OP_ON: begin
                            n_blank = !r_blank;
                        end
                        OP_ADD, OP_SUB: begin
                            n_stack[0]   = clamp_sum(arith_sum);
                            n_stack[1]   = c_stack[2];
                            n_stack[2]   = c_stack[3];
                            n_stack[3]   = c_stack[3];
                            n_entry_flag = 1'b0;
                        end
                        OP_MUL, OP_DIV: begin
                            n_stack[1]   = c_stack[2];
                            n_stack[2]   = c_stack[3];
                            n_stack[3]   = c_stack[3];
                            n_entry_flag = 1'b0;
                            if (i_cmd.op == OP_DIV && c_stack[0] == '0) begin
                                n_stack[0] = c_stack[1][VALUE_W-1] ? NEG_LIMIT : POS_LIMIT;
                                fault      = 1'b1;
                            end else begin
                                o_md_req.start = 1'b1;
                                load_out       = 1'b0;
                                n_state        = ST_WAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WAIT: begin
                if (i_md_rsp.done) begin
                    n_stack[0] = i_md_rsp.result;
                    load_out   = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            default: begin
                n_state = ST_EXEC;
            end
        endcase

        n_out_valid  = r_out_valid && !i_out_ready;
        n_shown      = r_shown;
        n_blank_out  = r_blank_out;
        n_active_out = r_active_out;
        n_fault_out  = r_fault_out;
        if (load_out) begin
            n_out_valid  = 1'b1;
            n_shown      = n_entry_flag ? $signed({1'b0, n_entry}) : n_stack[0];
            n_blank_out  = n_blank;
            n_active_out = n_entry_flag;
            n_fault_out  = fault;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_shown_value  = r_shown;
    assign o_screen_blank = r_blank_out;
    assign o_entry_active = r_active_out;
    assign o_divide_fault = r_fault_out;

endmodule
